// ===== src/srwr_pkg.sv =====
// Shared types and constants for the selective-repeat window round unit.
// No dependencies.
package srwr_pkg;

   localparam int MAX_SLOTS    = 8;
   localparam int MAX_SEQ_BITS = 4;

   // Register indexes on the configuration port
   localparam logic REG_SEQ_BITS = 1'b0;

   localparam logic [2:0] SEQ_BITS_RESET = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLOT,
      ST_SLIDE,
      ST_DONE
   } state_type;

endpackage

// ===== src/selective_repeat_window_round_unit.sv =====
// Top level of the selective-repeat window round unit: sequencer, window state and
// configuration port. Depends on srwr_pkg.
//
// Sequence: an accepted transfer runs through ST_SLOT, ST_SLIDE and ST_DONE before
// rsp_valid rises. W is the window size set by seq_bits (1, 2, 4 or 8). One slot is
// handled per cycle by the shared receiver compare bank, then one slot per cycle is
// shifted and refilled. ST_DONE hands off to the output register, and the next
// transfer is taken only back in ST_IDLE; req_stall is high while a round runs, and
// the hand-off waits while a stalled response is held.
// Reset (synchronous, active high) sets seq_bits to 3 and initialises both windows;
// a write to seq_bits re-initialises them the same way.
module selective_repeat_window_round_unit
   import srwr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_ok_mask,
   input  logic [7:0]  req_ack_lost_mask,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sent_mask,
   output logic [31:0] rsp_window_before,
   output logic [7:0]  rsp_accepted_mask,
   output logic [7:0]  rsp_duplicate_mask,
   output logic [7:0]  rsp_acked_mask,
   output logic [3:0]  rsp_slide_count,
   output logic [3:0]  rsp_next_send_seq,
   output logic [3:0]  rsp_next_recv_seq,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   state_type   state_ff, state_in;

   logic [2:0]  seq_bits_ff;
   logic [3:0]  slot_seq_ff [8];
   logic [7:0]  slot_acked_ff;
   logic [3:0]  recv_expect_ff [8];
   logic [3:0]  send_next_ff;
   logic [3:0]  recv_next_ff;

   logic [7:0]  ok_ff, lost_ff;
   logic [3:0]  cnt_ff;
   logic [3:0]  slide_ff;
   logic [7:0]  sent_ff, acc_ff, dup_ff, ackm_ff;
   logic [31:0] before_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_sent_ff, rsp_acc_ff, rsp_dup_ff, rsp_ackm_ff;
   logic [31:0] rsp_before_ff;
   logic [3:0]  rsp_slide_ff, rsp_send_ff, rsp_recv_ff;

   logic [2:0]  eff_bits;
   logic [3:0]  mod_mask;
   logic [3:0]  win_size;
   logic        cfg_write;
   logic        req_take;
   logic        rsp_free;
   logic        cnt_live;
   logic [2:0]  idx;
   logic [3:0]  cur_seq;
   logic        found;
   logic [2:0]  match_idx;
   logic [3:0]  first_unacked;
   logic [4:0]  src_pos;
   logic [31:0] before_now;

   // Effective sequence width: clamp into 1..MAX_SEQ_BITS
   always_comb begin
      eff_bits = seq_bits_ff;
      if (eff_bits == 3'd0) begin
         eff_bits = 3'd1;
      end
      if (eff_bits > 3'(MAX_SEQ_BITS)) begin
         eff_bits = 3'(MAX_SEQ_BITS);
      end
      mod_mask = 4'((5'd1 << eff_bits) - 5'd1);
      win_size = 4'(5'd1 << (eff_bits - 3'd1));
      if (win_size > 4'(MAX_SLOTS)) begin
         win_size = 4'(MAX_SLOTS);
      end
   end

   assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_SEQ_BITS);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign cnt_live  = cnt_ff < win_size;
   assign idx       = cnt_ff[2:0];
   assign cur_seq   = slot_seq_ff[idx];
   assign src_pos   = {1'b0, cnt_ff} + {1'b0, slide_ff};

   // Receiver search: lowest matching receiver slot wins
   always_comb begin
      found     = 1'b0;
      match_idx = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if ((4'(j) < win_size) && (recv_expect_ff[j] == cur_seq)) begin
            found     = 1'b1;
            match_idx = 3'(j);
         end
      end
   end

   // First unacknowledged slot, or W when all are acknowledged
   always_comb begin
      first_unacked = win_size;
      for (int j = 7; j >= 0; j--) begin
         if ((4'(j) < win_size) && !slot_acked_ff[j]) begin
            first_unacked = 4'(j);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         before_now[4*j +: 4] = slot_seq_ff[j];
      end
   end

   // Next state and handshake outputs
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (!cnt_live) begin
               state_in = ST_SLIDE;
            end
         end
         ST_SLIDE: begin
            if (!cnt_live) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Window state, round sequencing and configuration
   always_ff @(posedge clock) begin
      if (reset || cfg_write) begin
         logic [2:0] nb;
         logic [3:0] nw;
         nb = reset ? SEQ_BITS_RESET : pwdata[2:0];
         if (nb == 3'd0) begin
            nb = 3'd1;
         end
         if (nb > 3'(MAX_SEQ_BITS)) begin
            nb = 3'(MAX_SEQ_BITS);
         end
         nw = 4'(5'd1 << (nb - 3'd1));
         if (nw > 4'(MAX_SLOTS)) begin
            nw = 4'(MAX_SLOTS);
         end
         seq_bits_ff <= reset ? SEQ_BITS_RESET : pwdata[2:0];
         for (int j = 0; j < 8; j++) begin
            slot_seq_ff[j]    <= (4'(j) < nw) ? 4'(j) : 4'd0;
            recv_expect_ff[j] <= (4'(j) < nw) ? 4'(j) : 4'd0;
         end
         slot_acked_ff <= 8'd0;
         send_next_ff  <= nw;
         recv_next_ff  <= nw;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  ok_ff     <= req_frame_ok_mask;
                  lost_ff   <= req_ack_lost_mask;
                  before_ff <= before_now;
                  cnt_ff    <= 4'd0;
                  sent_ff   <= 8'd0;
                  acc_ff    <= 8'd0;
                  dup_ff    <= 8'd0;
                  ackm_ff   <= 8'd0;
               end
            end
            ST_SLOT: begin
               if (cnt_live) begin
                  if (!slot_acked_ff[idx]) begin
                     sent_ff[idx] <= 1'b1;
                     if (ok_ff[idx]) begin
                        if (found) begin
                           recv_expect_ff[match_idx] <= recv_next_ff;
                           recv_next_ff <= (recv_next_ff + 4'd1) & mod_mask;
                           acc_ff[idx]  <= 1'b1;
                        end else begin
                           dup_ff[idx]  <= 1'b1;
                        end
                        if (lost_ff[idx]) begin
                           slot_acked_ff[idx] <= 1'b0;
                        end else begin
                           slot_acked_ff[idx] <= 1'b1;
                           ackm_ff[idx]       <= 1'b1;
                        end
                     end
                  end
                  cnt_ff <= cnt_ff + 4'd1;
               end else begin
                  slide_ff <= first_unacked;
                  cnt_ff   <= 4'd0;
               end
            end
            ST_SLIDE: begin
               // Shift in place, ascending: the source never lies below the target
               if (cnt_live) begin
                  if (src_pos < {1'b0, win_size}) begin
                     slot_seq_ff[idx]   <= slot_seq_ff[src_pos[2:0]];
                     slot_acked_ff[idx] <= slot_acked_ff[src_pos[2:0]];
                  end else begin
                     slot_seq_ff[idx]   <= send_next_ff;
                     slot_acked_ff[idx] <= 1'b0;
                     send_next_ff       <= (send_next_ff + 4'd1) & mod_mask;
                  end
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Output register: load when the slot is free or being drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_sent_ff   <= sent_ff;
         rsp_before_ff <= before_ff;
         rsp_acc_ff    <= acc_ff;
         rsp_dup_ff    <= dup_ff;
         rsp_ackm_ff   <= ackm_ff;
         rsp_slide_ff  <= slide_ff;
         rsp_send_ff   <= send_next_ff;
         rsp_recv_ff   <= recv_next_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sent_mask      = rsp_sent_ff;
   assign rsp_window_before  = rsp_before_ff;
   assign rsp_accepted_mask  = rsp_acc_ff;
   assign rsp_duplicate_mask = rsp_dup_ff;
   assign rsp_acked_mask     = rsp_ackm_ff;
   assign rsp_slide_count    = rsp_slide_ff;
   assign rsp_next_send_seq  = rsp_send_ff;
   assign rsp_next_recv_seq  = rsp_recv_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SEQ_BITS) ? {29'd0, seq_bits_ff} : 32'd0;

endmodule

// ===== test/srwr_round_checker.sv =====
`timescale 1ns / 100ps
// Checker for the selective-repeat window round unit: watches both channels and the
// configuration port, predicts each round and compares it with the response.
// Depends on srwr_pkg.
module srwr_round_checker
   import srwr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_frame_ok_mask,
   input  logic [7:0]  req_ack_lost_mask,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_sent_mask,
   input  logic [31:0] rsp_window_before,
   input  logic [7:0]  rsp_accepted_mask,
   input  logic [7:0]  rsp_duplicate_mask,
   input  logic [7:0]  rsp_acked_mask,
   input  logic [3:0]  rsp_slide_count,
   input  logic [3:0]  rsp_next_send_seq,
   input  logic [3:0]  rsp_next_recv_seq,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          outstanding,
   output int          fail_count
);

   localparam int MAX_REPORTS = 10;
   localparam logic [2:0] SEQ_BITS_ADDR = {REG_SEQ_BITS, 2'b00};

   typedef struct packed {
      logic [7:0]  sent;
      logic [31:0] window_before;
      logic [7:0]  accepted;
      logic [7:0]  duplicate;
      logic [7:0]  acked;
      logic [3:0]  slide;
      logic [3:0]  send_seq;
      logic [3:0]  recv_seq;
   } round_type;

   logic [2:0] seq_bits_q;
   logic [3:0] slot_seq [MAX_SLOTS];
   logic       slot_acked [MAX_SLOTS];
   logic [3:0] recv_expect [MAX_SLOTS];
   logic [3:0] send_next;
   logic [3:0] recv_next;
   round_type  round_q [$];

   // Out-of-range settings clamp to 1..MAX_SEQ_BITS
   function automatic int seq_width(input logic [2:0] bits);
      if (bits == 3'd0) return 1;
      if (bits > MAX_SEQ_BITS) return MAX_SEQ_BITS;
      return int'(bits);
   endfunction

   task automatic init_windows();
      int w;
      int m;
      m = 1 << seq_width(seq_bits_q);
      w = m / 2;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_seq[i]    = (i < w) ? 4'(i) : 4'd0;
         recv_expect[i] = (i < w) ? 4'(i) : 4'd0;
         slot_acked[i]  = 1'b0;
      end
      send_next = 4'(w % m);
      recv_next = 4'(w % m);
   endtask

   task automatic play_round(input logic [7:0] ok, input logic [7:0] lost);
      round_type r;
      int        m;
      int        w;
      int        first_open;
      int        n;
      logic      found;
      m = 1 << seq_width(seq_bits_q);
      w = m / 2;
      r = '0;
      for (int i = 0; i < MAX_SLOTS; i++)
         r.window_before[4*i +: 4] = slot_seq[i];
      for (int i = 0; i < w; i++) begin
         if (!slot_acked[i]) begin
            r.sent[i] = 1'b1;
            if (ok[i]) begin
               // lowest matching receiver slot takes the frame
               found = 1'b0;
               for (int j = 0; j < w; j++) begin
                  if (!found && recv_expect[j] == slot_seq[i]) begin
                     recv_expect[j] = recv_next;
                     recv_next = 4'((int'(recv_next) + 1) % m);
                     found = 1'b1;
                  end
               end
               r.accepted[i]  = found;
               r.duplicate[i] = !found;
               slot_acked[i]  = !lost[i];
               r.acked[i]     = !lost[i];
            end
         end
      end
      first_open = w;
      for (int i = w - 1; i >= 0; i--)
         if (!slot_acked[i]) first_open = i;
      // shift the open tail down, then refill from send_next
      n = 0;
      for (int k = first_open; k < w; k++) begin
         slot_seq[n]   = slot_seq[k];
         slot_acked[n] = slot_acked[k];
         n++;
      end
      for (int k = n; k < w; k++) begin
         slot_seq[k]   = send_next;
         send_next     = 4'((int'(send_next) + 1) % m);
         slot_acked[k] = 1'b0;
      end
      r.slide    = 4'(first_open);
      r.send_seq = send_next;
      r.recv_seq = recv_next;
      round_q.push_back(r);
   endtask

   always @(posedge clock) begin
      round_type got;
      round_type want;
      if (reset) begin
         seq_bits_q = SEQ_BITS_RESET;
         init_windows();
         round_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.sent          = rsp_sent_mask;
            got.window_before = rsp_window_before;
            got.accepted      = rsp_accepted_mask;
            got.duplicate     = rsp_duplicate_mask;
            got.acked         = rsp_acked_mask;
            got.slide         = rsp_slide_count;
            got.send_seq      = rsp_next_send_seq;
            got.recv_seq      = rsp_next_recv_seq;
            if (round_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: response transfer with no round outstanding", $realtime);
            end else begin
               want = round_q.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $write("%0t: round mismatch (expected/actual) sent %h/%h window %h/%h ",
                            $realtime, want.sent, got.sent,
                            want.window_before, got.window_before);
                     $write("acc %h/%h dup %h/%h ack %h/%h ",
                            want.accepted, got.accepted, want.duplicate, got.duplicate,
                            want.acked, got.acked);
                     $display("slide %0d/%0d send %0d/%0d recv %0d/%0d",
                              want.slide, got.slide, want.send_seq, got.send_seq,
                              want.recv_seq, got.recv_seq);
                  end
               end
            end
         end
         if (psel && penable && pready && paddr == SEQ_BITS_ADDR) begin
            if (pwrite) begin
               seq_bits_q = pwdata[2:0];
               init_windows();
            end else if (prdata != {29'd0, seq_bits_q}) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: seq_bits read mismatch: expected %h, actual %h",
                           $realtime, {29'd0, seq_bits_q}, prdata);
            end
         end
         if (req_valid && !req_stall)
            play_round(req_frame_ok_mask, req_ack_lost_mask);
      end
      outstanding <= round_q.size();
   end

endmodule

// ===== test/selective_repeat_window_round_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the selective-repeat window round unit: clock, reset, stimulus
// and verdict. Depends on srwr_pkg, the unit itself and srwr_round_checker.
module selective_repeat_window_round_unit_tb;
   import srwr_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int ROUND_CYCLES = 2 * MAX_SLOTS + 3;
   localparam int PHASES       = 8;
   localparam int PHASE_ROUNDS = 165;
   localparam int N_DIRECTED   = 15;
   localparam logic [2:0] SEQ_BITS_ADDR = {REG_SEQ_BITS, 2'b00};

   // {frame_ok_mask, ack_lost_mask} pairs, applied left to right
   localparam logic [16*N_DIRECTED-1:0] DIRECTED_ROUNDS = {
      16'h00_00, 16'hFF_00, 16'h0F_0F, 16'h0F_00, 16'h05_00,
      16'hF0_F0, 16'h0A_02, 16'hFF_FF, 16'hFF_00, 16'h01_00,
      16'h0E_00, 16'hFF_55, 16'hAA_AA, 16'h00_FF, 16'hFF_00
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_frame_ok_mask = 8'd0;
   logic [7:0]  req_ack_lost_mask = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_sent_mask;
   logic [31:0] rsp_window_before;
   logic [7:0]  rsp_accepted_mask;
   logic [7:0]  rsp_duplicate_mask;
   logic [7:0]  rsp_acked_mask;
   logic [3:0]  rsp_slide_count;
   logic [3:0]  rsp_next_send_seq;
   logic [3:0]  rsp_next_recv_seq;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int outstanding;
   int fail_count;

   selective_repeat_window_round_unit u_dut (.*);

   srwr_round_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** selective_repeat_window_round_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] biased_mask(input int one_pct);
      logic [7:0] m;
      for (int i = 0; i < 8; i++)
         m[i] = $urandom_range(99) < one_pct;
      return m;
   endfunction

   // Mostly lossy-channel rounds, with uniform and all-or-nothing masks mixed in
   function automatic logic [15:0] draw_round();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6)
         return {biased_mask($urandom_range(60, 95)), biased_mask($urandom_range(5, 35))};
      if (pick < 8)
         return 16'($urandom);
      return {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00};
   endfunction

   function automatic logic [2:0] phase_seq_bits(input int p);
      case (p)
         0: return 3'd1;
         1: return 3'd4;
         2: return 3'd0;
         3: return 3'd2;
         4: return 3'd7;
         5: return 3'd3;
         6: return 3'd5;
         default: return 3'd4;
      endcase
   endfunction

   task automatic send_round(input logic [15:0] masks);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_frame_ok_mask <= masks[15:8];
      req_ack_lost_mask <= masks[7:0];
      // hold until the transfer goes through
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= SEQ_BITS_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int n = N_DIRECTED - 1; n >= 0; n--)
         send_round(DIRECTED_ROUNDS[16*n +: 16]);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         repeat (ROUND_CYCLES) @(posedge clock);
         csr_access(1'b1, {29'd0, phase_seq_bits(p)});
         csr_access(1'b0, 32'd0);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         for (int n = 0; n < PHASE_ROUNDS; n++) begin
            if (n == PHASE_ROUNDS / 2)
               drain();
            send_round(draw_round());
         end
      end

      drain();
      repeat (ROUND_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** selective_repeat_window_round_unit: PASSED **");
      else
         $display("** selective_repeat_window_round_unit: FAILED **");
      $finish;
   end

endmodule

// ===== selective_repeat_window_round_unit.f =====
src/srwr_pkg.sv
src/selective_repeat_window_round_unit.sv
test/srwr_round_checker.sv
test/selective_repeat_window_round_unit_tb.sv
